>>> rtl/drift_compensated_timer_bank_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer bank
// Short forms for clocked implication checks disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef DRIFT_COMPENSATED_TIMER_BANK_MACROS_SVH
`define DRIFT_COMPENSATED_TIMER_BANK_MACROS_SVH

// Same-cycle implication.
`define DCTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DCTB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dctb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Action codes, conversion constants and the stored timer entry type.
// ----------------------------------------------------------------------------
package dctb_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_TICKS = 2'd2;
    localparam logic [1:0] ACT_SLEEP = 2'd3;

    localparam logic [31:0] START_CLIP_MS = 32'h0012_FFED;
    localparam logic [31:0] START_CLIP_TO = 32'h0000_FFFF;
    localparam logic [31:0] START_MIN_MS  = 32'd100;
    localparam logic [15:0] TICK_MS       = 16'd50;

    // x / 50 == (x * RECIP_50) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_50    = 32'h51EB_851F;
    localparam int          RECIP_SHIFT = 36;

    // one timer slot as stored in RAM
    typedef struct packed {
        logic [15:0] remaining;
        logic [15:0] period;
        logic [15:0] drift;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> rtl/dctb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/drift_compensated_timer_bank.sv
// ----------------------------------------------------------------------------
// Drift-compensated timer bank
// One-shot timers counted in 50 ms ticks with per-timer drift carry.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis; tuser carries the action (start, stop,
//   advance by ticks, balance slept ms), tdata the slot and time operands.
//   Each expiring timer produces one item on m_axis (index, periods) with
//   tlast on the final expiry caused by that input item.
//   Throughput: one item at a time; s_axis_tready is high only when idle.
//   Start/stop pass through dispatch, RAM read and evaluate, with the ms / 50
//   split first when a start's ms value must be divided; a start or stop that
//   is ignored returns to idle from dispatch. Advance walks every slot (read,
//   evaluate, and emit on expiry, divider first if it overran its period);
//   sleep adds the ms / 50 split up front; m_axis stalls can hold it. Overrun /
//   period runs in one restoring divider (one quotient bit per cycle); ms / 50
//   is a reciprocal multiply. The slot RAM port gives one entry per read.
//   Reset clears the sequencer state, pending flag, output valid and divider
//   count, and marks every slot unwritten, so each reads as idle with zero
//   drift. When m_axis stalls, the block holds in its emit or flush step; one
//   expiry waits in a pending register so tlast can be placed once the walk is complete.
// ----------------------------------------------------------------------------
module drift_compensated_timer_bank #(
    parameter int TIMER_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] timer_select, [4] callback_valid, [36:5] time_ms,
    // [52:37] elapsed_ticks, [55:53] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] expired_timer, [19:4] periods_elapsed, [23:20] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    import dctb_pkg::*;

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_COUNT - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;  // decode latched item
    localparam logic [3:0] S_DIV1  = 4'd2;  // ms / 50 by reciprocal multiply
    localparam logic [3:0] S_RD    = 4'd3;  // RAM read issued
    localparam logic [3:0] S_EVAL  = 4'd4;  // entry available, update
    localparam logic [3:0] S_DIV2  = 4'd5;  // overrun / period
    localparam logic [3:0] S_EMIT  = 4'd6;  // write back expired slot
    localparam logic [3:0] S_FLUSH = 4'd7;  // release last pending result
    localparam logic [3:0] S_REM   = 4'd8;  // ticks and leftover ms from quotient

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_act, n_act;
    logic [3:0]  r_sel, n_sel;
    logic        r_cbv, n_cbv;
    logic [31:0] r_ms, n_ms;
    logic [15:0] r_tk, n_tk;
    logic [5:0]  r_msrem, n_msrem;
    logic [27:0] r_q50, n_q50;
    logic [IW-1:0] r_idx, n_idx;
    logic        r_rd_vld, n_rd_vld;
    logic [15:0] r_drift, n_drift;
    logic [15:0] r_periods, n_periods;
    logic        r_pend_vld, n_pend_vld;
    logic [IW-1:0] r_pend_idx, n_pend_idx;
    logic [15:0] r_pend_per, n_pend_per;
    logic        r_out_valid, n_out_valid;
    logic [3:0]  r_out_idx, n_out_idx;
    logic [15:0] r_out_per, n_out_per;
    logic        r_out_last, n_out_last;
    logic [TIMER_COUNT-1:0] r_vld, n_vld;

    // restoring divider for overrun / period
    logic [5:0]  r_dv_cnt, n_dv_cnt;
    logic [31:0] r_dv_q, n_dv_q;
    logic [15:0] r_dv_r, n_dv_r;
    logic [15:0] r_dv_d, n_dv_d;
    logic [16:0] dv_trial;
    logic        dv_ge;

    // ms / 50 split
    logic [63:0] ms_prod;
    logic [31:0] q_x50;
    logic [31:0] ms_left;

    // RAM port
    logic        mem_we;
    t_entry      mem_wdata;
    t_entry      mem_rdata;
    t_entry      ent;

    // scratch
    logic        out_free;
    logic        sel_ok;
    logic [31:0] t_clip;
    logic [15:0] d1, d2, over;
    logic [15:0] drift_add;

    dctb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign ent      = r_rd_vld ? mem_rdata : '0;  // unwritten slot reads idle
    assign out_free = !r_out_valid || m_axis_tready;
    assign sel_ok   = 32'(r_sel) < 32'(TIMER_COUNT);
    assign t_clip   = (r_ms > START_CLIP_MS) ? START_CLIP_TO : r_ms;
    assign dv_trial = {r_dv_r, r_dv_q[31]};
    assign dv_ge    = dv_trial >= {1'b0, r_dv_d};
    assign drift_add = 16'(r_dv_r * TICK_MS);
    assign ms_prod  = {32'd0, r_ms} * {32'd0, RECIP_50};
    assign q_x50    = {4'd0, r_q50} * {16'd0, TICK_MS};
    assign ms_left  = r_ms - q_x50;

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_sel       = r_sel;
        n_cbv       = r_cbv;
        n_ms        = r_ms;
        n_tk        = r_tk;
        n_msrem     = r_msrem;
        n_q50       = r_q50;
        n_idx       = r_idx;
        n_rd_vld    = r_rd_vld;
        n_drift     = r_drift;
        n_periods   = r_periods;
        n_pend_vld  = r_pend_vld;
        n_pend_idx  = r_pend_idx;
        n_pend_per  = r_pend_per;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_idx   = r_out_idx;
        n_out_per   = r_out_per;
        n_out_last  = r_out_last;
        n_vld       = r_vld;
        n_dv_cnt    = r_dv_cnt;
        n_dv_q      = r_dv_q;
        n_dv_r      = r_dv_r;
        n_dv_d      = r_dv_d;
        mem_we      = 1'b0;
        mem_wdata   = ent;
        d1          = ent.drift;
        d2          = ent.drift;
        over        = '0;

        // divider step
        if (r_dv_cnt != '0) begin
            n_dv_r   = dv_ge ? 16'(dv_trial - {1'b0, r_dv_d}) : dv_trial[15:0];
            n_dv_q   = {r_dv_q[30:0], dv_ge};
            n_dv_cnt = r_dv_cnt - 6'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act   = s_axis_tuser;
                    n_sel   = s_axis_tdata[3:0];
                    n_cbv   = s_axis_tdata[4];
                    n_ms    = s_axis_tdata[36:5];
                    n_tk    = s_axis_tdata[52:37];
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_msrem = '0;
                n_idx   = '0;
                case (r_act)
                    ACT_START: begin
                        n_idx = IW'(r_sel);
                        if (!sel_ok || !r_cbv) begin
                            n_state = S_IDLE;
                        end else if (t_clip < START_MIN_MS) begin
                            n_tk    = 16'd1;
                            n_state = S_RD;
                        end else begin
                            n_ms    = t_clip;
                            n_state = S_DIV1;
                        end
                    end
                    ACT_STOP: begin
                        n_idx   = IW'(r_sel);
                        n_state = sel_ok ? S_RD : S_IDLE;
                    end
                    ACT_TICKS: begin
                        n_state = S_RD;
                    end
                    default: begin  // sleep: split ms into ticks and leftover ms
                        n_state = S_DIV1;
                    end
                endcase
            end
            S_DIV1: begin
                n_q50   = ms_prod[63:RECIP_SHIFT];
                n_state = S_REM;
            end
            S_REM: begin
                n_tk    = r_q50[15:0];
                n_msrem = ms_left[5:0];
                n_state = S_RD;
            end
            S_RD: begin
                n_rd_vld = r_vld[r_idx];
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                case (r_act)
                    ACT_START: begin
                        mem_we              = 1'b1;
                        mem_wdata.remaining = r_tk;
                        mem_wdata.period    = r_tk;
                        if (r_tk > 16'd1 && ent.drift >= TICK_MS) begin
                            mem_wdata.remaining = r_tk - 16'd1;
                            mem_wdata.drift     = ent.drift - TICK_MS;
                        end
                        n_state = S_IDLE;
                    end
                    ACT_STOP: begin
                        mem_we              = 1'b1;
                        mem_wdata.remaining = '0;
                        mem_wdata.period    = '0;
                        n_state             = S_IDLE;
                    end
                    default: begin
                        if (r_act == ACT_SLEEP) begin
                            d1 = ent.drift + 16'(r_msrem);
                            if (d1 >= TICK_MS) begin
                                d1 = d1 - TICK_MS;
                            end
                        end
                        d2   = d1;
                        over = r_tk - ent.remaining;
                        if (r_act == ACT_TICKS && d1 >= TICK_MS) begin
                            over = over + 16'd1;
                            d2   = d1 - TICK_MS;
                        end
                        if (ent.remaining == '0) begin
                            // idle slot: untouched
                            if (r_idx == LAST_IDX) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_state = S_RD;
                            end
                        end else if (ent.remaining <= r_tk) begin
                            n_drift   = d2;
                            n_periods = 16'd1;
                            if (ent.period != '0 && over >= ent.period) begin
                                n_dv_q   = {over, 16'd0};
                                n_dv_r   = '0;
                                n_dv_d   = ent.period;
                                n_dv_cnt = 6'd16;
                                n_state  = S_DIV2;
                            end else begin
                                n_state  = S_EMIT;
                            end
                        end else begin
                            mem_we              = 1'b1;
                            mem_wdata.remaining = ent.remaining - r_tk;
                            mem_wdata.drift     = d1;
                            if (r_idx == LAST_IDX) begin
                                n_state = S_FLUSH;
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_state = S_RD;
                            end
                        end
                    end
                endcase
            end
            S_DIV2: begin
                if (r_dv_cnt == '0) begin
                    n_periods = 16'd1 + r_dv_q[15:0];
                    n_drift   = r_drift + drift_add;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = 4'(r_pend_idx);
                        n_out_per   = r_pend_per;
                        n_out_last  = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_idx  = r_idx;
                    n_pend_per  = r_periods;
                    mem_we      = 1'b1;
                    mem_wdata   = '{remaining: 16'd0, period: 16'd0, drift: r_drift};
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = 4'(r_pend_idx);
                    n_out_per   = r_pend_per;
                    n_out_last  = 1'b1;
                    n_pend_vld  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (mem_we) begin
            n_vld[r_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_dv_cnt    <= '0;
        end else begin
            r_state     <= n_state;
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= n_out_valid;
            r_vld       <= n_vld;
            r_dv_cnt    <= n_dv_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_sel      <= n_sel;
        r_cbv      <= n_cbv;
        r_ms       <= n_ms;
        r_tk       <= n_tk;
        r_msrem    <= n_msrem;
        r_q50      <= n_q50;
        r_idx      <= n_idx;
        r_rd_vld   <= n_rd_vld;
        r_drift    <= n_drift;
        r_periods  <= n_periods;
        r_pend_idx <= n_pend_idx;
        r_pend_per <= n_pend_per;
        r_out_idx  <= n_out_idx;
        r_out_per  <= n_out_per;
        r_out_last <= n_out_last;
        r_dv_q     <= n_dv_q;
        r_dv_r     <= n_dv_r;
        r_dv_d     <= n_dv_d;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_per, r_out_idx};
    assign m_axis_tlast  = r_out_last;

`include "drift_compensated_timer_bank_macros.svh"

    `DCTB_ASSERT_IMP(a_idle_div_quiet, r_state == S_IDLE, r_dv_cnt == '0, "divider busy while idle")
    `DCTB_ASSERT_IMP(a_idle_no_pend, r_state == S_IDLE, !r_pend_vld, "pending expiry left at idle")
    `DCTB_ASSERT_IMP(a_eval_after_rd, r_state == S_EVAL, $past(r_state) == S_RD, "eval without read")
    `DCTB_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
    `DCTB_ASSERT_NXT(a_accept_disp, s_axis_tvalid && s_axis_tready, r_state == S_DISP, "accept lost")

endmodule
